// File: sv/tapv_pkg.sv
package tapv_pkg;

  localparam int AXES       = 3;
  localparam int CLAMP_AXES = 2;    // x and y obey output_limit, z does not
  localparam int POS_W      = 32;
  localparam int GAIN_W     = 32;
  localparam int LIM_W      = 31;
  localparam int FRAC_SHIFT = 24;
  localparam int PROD_W     = POS_W + GAIN_W - FRAC_SHIFT;
  localparam int ACC_W      = PROD_W + 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ILIM = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OLIM = 3'd4;

  localparam logic [GAIN_W-1:0] RST_KP   = 32'd14763950;
  localparam logic [GAIN_W-1:0] RST_KI   = 32'd3355;
  localparam logic [GAIN_W-1:0] RST_KD   = 32'd28185723;
  localparam logic [LIM_W-1:0]  RST_ILIM = 31'd32768000;
  localparam logic [LIM_W-1:0]  RST_OLIM = 31'd0;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [POS_W:0]    pos_ext_t;
  typedef logic        [GAIN_W-1:0] gain_t;
  typedef logic        [LIM_W-1:0]  lim_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef struct packed {
    pos_t err;
    pos_t sum;
    pos_t der;
  } terms_t;

  typedef struct packed {
    prod_t p;
    prod_t i;
    prod_t d;
  } prods_t;

  localparam pos_t POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
  localparam pos_t POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

  // saturate a 33-bit value to 32 bits
  function automatic pos_t sat_ext(input pos_ext_t v);
    pos_t r;
    if (v[POS_W] != v[POS_W-1]) begin
      r = v[POS_W] ? POS_MIN : POS_MAX;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

  // saturate the accumulated drive to 32 bits
  function automatic pos_t sat_acc(input acc_t v);
    pos_t r;
    if ((&v[ACC_W-1:POS_W-1]) || !(|v[ACC_W-1:POS_W-1])) begin
      r = v[POS_W-1:0];
    end else begin
      r = v[ACC_W-1] ? POS_MIN : POS_MAX;
    end
    return r;
  endfunction

  // clamp to [-lim, +lim]
  function automatic pos_t clamp_sym(input pos_ext_t v, input lim_t lim);
    pos_ext_t lim_s;
    pos_ext_t neg_s;
    pos_t     r;
    lim_s = $signed({2'b00, lim});
    neg_s = -lim_s;
    if (v > lim_s) begin
      r = lim_s[POS_W-1:0];
    end else if (v < neg_s) begin
      r = neg_s[POS_W-1:0];
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: sv/tapv_in_if.sv
interface tapv_in_if;
  import tapv_pkg::*;

  logic valid;
  logic ready;
  pos_t target_x;
  pos_t target_y;
  pos_t target_z;
  pos_t measured_x;
  pos_t measured_y;
  pos_t measured_z;

  modport source (
    output valid, target_x, target_y, target_z, measured_x, measured_y, measured_z,
    input  ready
  );

  modport sink (
    input  valid, target_x, target_y, target_z, measured_x, measured_y, measured_z,
    output ready
  );
endinterface

// File: sv/tapv_out_if.sv
interface tapv_out_if;
  import tapv_pkg::*;

  logic valid;
  logic ready;
  pos_t drive_x;
  pos_t drive_y;
  pos_t drive_z;

  modport source (
    output valid, drive_x, drive_y, drive_z,
    input  ready
  );

  modport sink (
    input  valid, drive_x, drive_y, drive_z,
    output ready
  );
endinterface

// File: sv/three_axis_pid_velocity_top.sv
// Three-axis PID velocity controller. Each request carries target and measured
// positions (signed Q16.16) for x, y and z; each gives one result with three
// drives (signed Q16.16). Per axis: err = sat(target - measured), the error sum
// is err added to the stored sum and clamped to +/-integral_limit, the
// derivative is sat(err - error from two requests back), and the drive is
// floor(kp*err) + floor(ki*sum) + floor(kd*der) (gains unsigned Q8.24),
// saturated to 32 bits; x and y are then clamped to +/-output_limit unless it
// is zero. Throughput is one request per clock unless the output stalls; a
// result passes three register stages (error/sum, multiply, add/saturate),
// with the per-axis error state updated in the first stage and one
// registered multiply per term. Stages hold while the result register is
// stalled and bubbles collapse, so requests keep flowing while a result
// waits until all three stages hold a request.
// Config: cfg_index 0 kp, 1 ki, 2 kd, 3 integral_limit (31 b),
// 4 output_limit (31 b); higher indexes are ignored. Write only while idle.
module three_axis_pid_velocity_top (
  input  logic                            clk,
  input  logic                            rst_n,
  tapv_in_if.sink                         in_req,
  tapv_out_if.source                      out_rsp,
  input  logic                            cfg_we,
  input  logic [tapv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tapv_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tapv_pkg::*;

  // config registers
  gain_t kp_r;
  gain_t ki_r;
  gain_t kd_r;
  lim_t  ilim_r;
  lim_t  olim_r;

  // stage valids: s1 = error terms, s2 = products, out = result register
  logic s1_v_r;
  logic s2_v_r;
  logic out_v_r;

  logic out_ld;
  logic s2_ld;
  logic in_acc;

  pos_t   target   [AXES];
  pos_t   measured [AXES];
  terms_t terms    [AXES];
  prods_t prods    [AXES];
  pos_t   drive    [AXES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= RST_KP;
      ki_r   <= RST_KI;
      kd_r   <= RST_KD;
      ilim_r <= RST_ILIM;
      olim_r <= RST_OLIM;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KP:   kp_r   <= cfg_data;
        CFG_KI:   ki_r   <= cfg_data;
        CFG_KD:   kd_r   <= cfg_data;
        CFG_ILIM: ilim_r <= cfg_data[LIM_W-1:0];
        CFG_OLIM: olim_r <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  assign out_ld       = !out_v_r || out_rsp.ready;
  assign s2_ld        = !s2_v_r || out_ld;
  assign in_req.ready = !s1_v_r || s2_ld;
  assign in_acc       = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_req.ready) begin
        s1_v_r <= in_req.valid;
      end
      if (s2_ld) begin
        s2_v_r <= s1_v_r;
      end
      if (out_ld) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  assign target[0]   = in_req.target_x;
  assign target[1]   = in_req.target_y;
  assign target[2]   = in_req.target_z;
  assign measured[0] = in_req.measured_x;
  assign measured[1] = in_req.measured_y;
  assign measured[2] = in_req.measured_z;

  tapv_integ u_integ (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (in_acc),
    .target   (target),
    .measured (measured),
    .ilim     (ilim_r),
    .terms    (terms)
  );

  tapv_prod u_prod (
    .clk   (clk),
    .ld    (s2_ld && s1_v_r),
    .kp    (kp_r),
    .ki    (ki_r),
    .kd    (kd_r),
    .terms (terms),
    .prods (prods)
  );

  tapv_drive u_drive (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (out_ld && s2_v_r),
    .olim  (olim_r),
    .prods (prods),
    .drive (drive)
  );

  assign out_rsp.valid   = out_v_r;
  assign out_rsp.drive_x = drive[0];
  assign out_rsp.drive_y = drive[1];
  assign out_rsp.drive_z = drive[2];

  // no request dropped between stages
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ld) |=> s1_v_r)
    else $error("stage 1 request lost");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s2_ld) |=> s2_v_r)
    else $error("stage 1 request not passed on");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_ld) |=> s2_v_r)
    else $error("stage 2 request lost");

endmodule

// File: sv/tapv_integ.sv
module tapv_integ (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            acc,
  input  tapv_pkg::pos_t  target   [tapv_pkg::AXES],
  input  tapv_pkg::pos_t  measured [tapv_pkg::AXES],
  input  tapv_pkg::lim_t  ilim,
  output tapv_pkg::terms_t terms   [tapv_pkg::AXES]
);
  import tapv_pkg::*;

  pos_t   es_r    [AXES];
  pos_t   prev_r  [AXES];
  pos_t   older_r [AXES];
  terms_t terms_r [AXES];

  pos_t   err_c [AXES];
  pos_t   sum_c [AXES];
  pos_t   der_c [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      err_c[i] = sat_ext(pos_ext_t'({target[i][POS_W-1], target[i]})
                       - pos_ext_t'({measured[i][POS_W-1], measured[i]}));
      // sum of a clamped value and a 32-bit error fits in 33 bits
      sum_c[i] = clamp_sym(pos_ext_t'({es_r[i][POS_W-1], es_r[i]})
                         + pos_ext_t'({err_c[i][POS_W-1], err_c[i]}), ilim);
      // derivative spans two steps
      der_c[i] = sat_ext(pos_ext_t'({err_c[i][POS_W-1], err_c[i]})
                       - pos_ext_t'({older_r[i][POS_W-1], older_r[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < AXES; i++) begin
        es_r[i]    <= '0;
        prev_r[i]  <= '0;
        older_r[i] <= '0;
      end
    end else if (acc) begin
      for (int i = 0; i < AXES; i++) begin
        es_r[i]    <= sum_c[i];
        older_r[i] <= prev_r[i];
        prev_r[i]  <= err_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int i = 0; i < AXES; i++) begin
        terms_r[i] <= '{err: err_c[i], sum: sum_c[i], der: der_c[i]};
      end
    end
  end

  assign terms = terms_r;

  // stored x-axis sum never leaves the integral window it was clamped to
  assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> ($signed(es_r[0]) <= $signed({1'b0, $past(ilim)})) &&
            ($signed(es_r[0]) >= -$signed({1'b0, $past(ilim)})))
    else $error("error sum outside integral limit");

endmodule

// File: sv/tapv_prod.sv
module tapv_prod (
  input  logic             clk,
  input  logic             ld,
  input  tapv_pkg::gain_t  kp,
  input  tapv_pkg::gain_t  ki,
  input  tapv_pkg::gain_t  kd,
  input  tapv_pkg::terms_t terms [tapv_pkg::AXES],
  output tapv_pkg::prods_t prods [tapv_pkg::AXES]
);
  import tapv_pkg::*;

  prods_t prods_r [AXES];
  prods_t prods_c [AXES];

  // Q16.16 x Q8.24, arithmetic shift drops 24 bits (floor)
  function automatic prod_t mul_q24(input pos_t v, input gain_t g);
    logic signed [POS_W+GAIN_W:0] p;
    p = (POS_W+GAIN_W+1)'(v) * (POS_W+GAIN_W+1)'($signed({1'b0, g}));
    return p[POS_W+GAIN_W-1:FRAC_SHIFT];
  endfunction

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      prods_c[i].p = mul_q24(terms[i].err, kp);
      prods_c[i].i = mul_q24(terms[i].sum, ki);
      prods_c[i].d = mul_q24(terms[i].der, kd);
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      prods_r <= prods_c;
    end
  end

  assign prods = prods_r;

endmodule

// File: sv/tapv_drive.sv
module tapv_drive (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ld,
  input  tapv_pkg::lim_t   olim,
  input  tapv_pkg::prods_t prods [tapv_pkg::AXES],
  output tapv_pkg::pos_t   drive [tapv_pkg::AXES]
);
  import tapv_pkg::*;

  pos_t drive_r [AXES];
  pos_t drive_c [AXES];
  acc_t total_c [AXES];
  pos_t sat_c   [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      total_c[i] = acc_t'(prods[i].p) + acc_t'(prods[i].i) + acc_t'(prods[i].d);
      sat_c[i]   = sat_acc(total_c[i]);
      if ((olim != '0) && (i < CLAMP_AXES)) begin
        drive_c[i] = clamp_sym(pos_ext_t'({sat_c[i][POS_W-1], sat_c[i]}), olim);
      end else begin
        drive_c[i] = sat_c[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      drive_r <= drive_c;
    end
  end

  assign drive = drive_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (ld && (olim != '0)) |=>
      ($signed(drive_r[0]) <= $signed({1'b0, $past(olim)})) &&
      ($signed(drive_r[0]) >= -$signed({1'b0, $past(olim)})))
    else $error("x drive outside output limit");

endmodule
